/* hw/rtl/shfd_pkg.sv */
// shared types and constants of the sync-header frame deframer
package shfd_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int CNT_W        = 17;

  localparam logic [7:0]  SYNC_B0     = 8'hFA;
  localparam logic [7:0]  SYNC_B1     = 8'hFB;
  localparam logic [7:0]  SYNC_B2     = 8'hFC;
  localparam logic [7:0]  SYNC_B3     = 8'hFD;
  localparam logic [23:0] SYNC_PREFIX = {SYNC_B0, SYNC_B1, SYNC_B2};
  localparam logic [15:0] SYNC_SUM    = 16'({8'h00, SYNC_B0} + {8'h00, SYNC_B1}
                                          + {8'h00, SYNC_B2} + {8'h00, SYNC_B3});

  localparam logic [15:0] MAX_LENGTH_RST = 16'd1024;
  localparam logic [15:0] LEN_SAT        = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BODY   = 2'd0,
    KIND_GOOD   = 2'd1,
    KIND_BADSUM = 2'd2,
    KIND_BADLEN = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] command_code;
    logic [7:0]  data_byte;
    kind_t       kind;
    logic        frame_end;
  } result_t;

endpackage

/* hw/rtl/sync_header_frame_deframer.sv */
// sync-header frame deframer: parser front end feeding a result queue
// a result is written into the queue as its byte is accepted and reaches the output from the queue head
// throughput: one byte per cycle; input stalls only while the 4-entry queue is full
// each byte gives at most one result, so a free queue slot is all a request needs
// reset: synchronous active-low rst_n, back to hunting, queue empty, max_length 1024
module sync_header_frame_deframer import shfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // data_byte, command_code, frame_length
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // frame_end
);

  logic    q_full;
  logic    res_valid;
  result_t res;
  result_t head;

  assign in_tready = !q_full;

  shfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (in_tvalid && in_tready),
    .byte_data   (in_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  shfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .full       (q_full),
    .head_valid (out_tvalid),
    .head_data  (head),
    .pop_ready  (out_tready)
  );

  assign out_tdata = {head.frame_length, head.command_code, head.data_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.frame_end;

endmodule

/* hw/rtl/shfd_parser.sv */
// front end: sync hunt, header decode, length check, body pass-through and checksum check
module shfd_parser import shfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        byte_valid,
  input  logic [7:0]  byte_data,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_BODY    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  localparam logic [CNT_W-1:0] POS_CMD_HI = CNT_W'(HEADER_BYTES - 6);
  localparam logic [CNT_W-1:0] POS_CMD_LO = CNT_W'(HEADER_BYTES - 5);
  localparam logic [CNT_W-1:0] POS_LEN    = CNT_W'(HEADER_BYTES - 4);
  localparam logic [CNT_W-1:0] POS_LAST   = CNT_W'(HEADER_BYTES - 1);
  localparam logic [CNT_W-1:0] POS_START  = CNT_W'(4);

  phase_t           phase_r,  phase_nxt;
  logic [23:0]      window_r, window_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [31:0]      len_r,    len_nxt;
  logic [15:0]      cmd_r,    cmd_nxt;
  logic [15:0]      sum_r,    sum_nxt;
  logic [7:0]       thigh_r,  thigh_nxt;
  logic [15:0]      maxlen_r;

  logic [CNT_W-1:0] count_inc;
  logic [15:0]      got_sum;

  assign count_inc = count_r + CNT_W'(1);
  assign got_sum   = {thigh_r, byte_data};

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    cmd_nxt    = cmd_r;
    sum_nxt    = sum_r;
    thigh_nxt  = thigh_r;
    res_valid  = 1'b0;
    res.kind      = KIND_BODY;
    res.data_byte = 8'h00;
    res.frame_end = 1'b0;
    if (byte_valid) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (window_r == SYNC_PREFIX && byte_data == SYNC_B3) begin
            phase_nxt  = PH_HEADER;
            count_nxt  = POS_START;
            sum_nxt    = SYNC_SUM;
            len_nxt    = 32'h0;
            cmd_nxt    = 16'h0;
            thigh_nxt  = 8'h00;
            window_nxt = 24'h0;
          end else begin
            window_nxt = {window_r[15:0], byte_data};
          end
        end
        PH_HEADER: begin
          sum_nxt = sum_r + {8'h00, byte_data};
          if (count_r == POS_CMD_HI || count_r == POS_CMD_LO) begin
            cmd_nxt = {cmd_r[7:0], byte_data};
          end
          if (count_r >= POS_LEN) begin
            len_nxt = {len_r[23:0], byte_data};
          end
          if (count_r >= POS_LAST) begin
            if (len_nxt < 32'd2 || len_nxt > {16'h0, maxlen_r}) begin
              res_valid     = 1'b1;
              res.kind      = KIND_BADLEN;
              res.frame_end = 1'b1;
              phase_nxt     = PH_HUNT;
              window_nxt    = 24'h0;
              count_nxt     = '0;
            end else begin
              count_nxt = '0;
              phase_nxt = (len_nxt == 32'd2) ? PH_TRAILER : PH_BODY;
            end
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_BODY: begin
          sum_nxt       = sum_r + {8'h00, byte_data};
          res_valid     = 1'b1;
          res.data_byte = byte_data;
          // length is within 3..65535 here, so 17 bits hold length - 2
          if (count_inc >= len_r[CNT_W-1:0] - CNT_W'(2)) begin
            count_nxt = '0;
            phase_nxt = PH_TRAILER;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_TRAILER: begin
          if (count_r == '0) begin
            thigh_nxt = byte_data;
            count_nxt = CNT_W'(1);
          end else begin
            res_valid     = 1'b1;
            res.kind      = (got_sum == sum_r) ? KIND_GOOD : KIND_BADSUM;
            res.frame_end = 1'b1;
            phase_nxt     = PH_HUNT;
            window_nxt    = 24'h0;
            count_nxt     = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
    // fields shown reflect the length and command after this byte
    res.command_code = cmd_nxt;
    res.frame_length = (len_nxt > {16'h0, LEN_SAT}) ? LEN_SAT : len_nxt[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      window_r <= 24'h0;
      count_r  <= '0;
      len_r    <= 32'h0;
      cmd_r    <= 16'h0;
      sum_r    <= 16'h0;
      thigh_r  <= 8'h00;
      maxlen_r <= MAX_LENGTH_RST;
    end else begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      count_r  <= count_nxt;
      len_r    <= len_nxt;
      cmd_r    <= cmd_nxt;
      sum_r    <= sum_nxt;
      thigh_r  <= thigh_nxt;
      if (cfg_wr_en) begin
        maxlen_r <= cfg_wr_data;
      end
    end
  end

endmodule

/* hw/rtl/shfd_queue.sv */
// back end: small result queue whose head drives the output channel
module shfd_queue import shfd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    head_valid,
  output result_t head_data,
  input  logic    pop_ready
);

  result_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r,    cnt_nxt;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_pop     = head_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* dv/sync_header_frame_deframer_tb.sv */
// testbench for the sync-header frame deframer: directed and random byte streams checked against a predictor
module sync_header_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shfd_pkg::*;

  localparam int HDR_LEN = 20;
  localparam int LONG_HOLD = 300;
  localparam logic [7:0] SW0 = 8'hFA;
  localparam logic [7:0] SW1 = 8'hFB;
  localparam logic [7:0] SW2 = 8'hFC;
  localparam logic [7:0] SW3 = 8'hFD;

  typedef enum logic [1:0] {P_HUNT, P_HEADER, P_BODY, P_TRAILER} parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // data_byte, command_code, frame_length
  logic [1:0]  out_tuser;         // kind
  logic        out_tlast;         // frame_end

  // predictor state
  parse_phase_t parse_ph = P_HUNT;
  logic [23:0]  hunt_window = '0;
  logic [16:0]  parse_pos = '0;
  logic [31:0]  len_acc = '0;
  logic [15:0]  cmd_acc = '0;
  logic [15:0]  sum_acc = '0;
  logic [7:0]   trailer_msb = '0;
  logic [15:0]  max_len_model = 16'd1024;

  logic [7:0]   rx_stream [$];
  result_t      reports_due [$];

  int unsigned  send_idle_pct = 23;
  int unsigned  recv_idle_pct = 68;
  logic         long_stall_go = 1'b0;
  logic         rx_blocked = 1'b0;
  int unsigned  n_sent = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_errors = 0;
  int unsigned  kind_seen [4] = '{0, 0, 0, 0};

  sync_header_frame_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial forever #1 clk = ~clk;

  function automatic void put_rx(logic [7:0] b);
    rx_stream.insert(rx_stream.size(), b);
  endfunction

  function automatic void add_report(kind_t k, logic [7:0] d);
    result_t r;
    r.kind = k;
    r.data_byte = d;
    r.command_code = cmd_acc;
    r.frame_length = (len_acc > 32'hFFFF) ? 16'hFFFF : len_acc[15:0];
    r.frame_end = (k != KIND_BODY);
    reports_due.insert(reports_due.size(), r);
  endfunction

  function automatic void resume_hunt();
    parse_ph = P_HUNT;
    hunt_window = '0;
    parse_pos = '0;
  endfunction

  // advances the parser by one byte and queues the report it gives, if any
  function automatic void deframe_byte(logic [7:0] b);
    logic [16:0] pos;
    logic [15:0] got;
    pos = parse_pos;
    case (parse_ph)
      P_HUNT: begin
        if (hunt_window == {SW0, SW1, SW2} && b == SW3) begin
          parse_ph = P_HEADER;
          parse_pos = 17'd4;
          sum_acc = 16'd0 + SW0 + SW1 + SW2 + SW3;
          len_acc = '0;
          cmd_acc = '0;
          trailer_msb = '0;
          hunt_window = '0;
        end else begin
          hunt_window = {hunt_window[15:0], b};
        end
      end
      P_HEADER: begin
        sum_acc = sum_acc + b;
        if (pos == HDR_LEN - 6 || pos == HDR_LEN - 5) cmd_acc = {cmd_acc[7:0], b};
        if (pos >= HDR_LEN - 4) len_acc = {len_acc[23:0], b};
        if (pos + 1 >= HDR_LEN) begin
          if (len_acc < 2 || len_acc > max_len_model) begin
            add_report(KIND_BADLEN, 8'h00);
            resume_hunt();
          end else begin
            parse_pos = '0;
            parse_ph = (len_acc == 2) ? P_TRAILER : P_BODY;
          end
        end else begin
          parse_pos = pos + 1;
        end
      end
      P_BODY: begin
        sum_acc = sum_acc + b;
        add_report(KIND_BODY, b);
        parse_pos = pos + 1;
        if (parse_pos >= len_acc - 2) begin
          parse_pos = '0;
          parse_ph = P_TRAILER;
        end
      end
      default: begin
        if (pos == 0) begin
          trailer_msb = b;
          parse_pos = 17'd1;
        end else begin
          got = {trailer_msb, b};
          add_report((got == sum_acc) ? KIND_GOOD : KIND_BADSUM, 8'h00);
          resume_hunt();
        end
      end
    endcase
  endfunction

  // queues one frame; body and trailer follow only when the length is acceptable
  function automatic int queue_frame(logic [15:0] cmd, logic [31:0] len, bit sum_ok);
    logic [7:0]  hdr [HDR_LEN];
    logic [15:0] sum;
    logic [7:0]  v;
    hdr[0] = SW0;
    hdr[1] = SW1;
    hdr[2] = SW2;
    hdr[3] = SW3;
    for (int i = 4; i < HDR_LEN - 6; i++) hdr[i] = 8'($urandom);
    hdr[14] = cmd[15:8];
    hdr[15] = cmd[7:0];
    hdr[16] = len[31:24];
    hdr[17] = len[23:16];
    hdr[18] = len[15:8];
    hdr[19] = len[7:0];
    sum = '0;
    foreach (hdr[i]) begin
      put_rx(hdr[i]);
      sum = sum + hdr[i];
    end
    if (len < 2 || len > max_len_model) return HDR_LEN;
    for (int i = 0; i < len - 2; i++) begin
      v = 8'($urandom);
      put_rx(v);
      sum = sum + v;
    end
    if (!sum_ok) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
    put_rx(sum[15:8]);
    put_rx(sum[7:0]);
    return HDR_LEN + len;
  endfunction

  function automatic logic [31:0] pick_length();
    int unsigned top;
    int unsigned roll;
    top = (max_len_model < 2) ? 2 : max_len_model;
    roll = $urandom_range(99);
    if (roll < 3) return $urandom_range(1);
    if (roll < 6) return top + 1;
    if (roll < 9) return $urandom;
    if (roll < 13) return (top <= 400) ? top : $urandom_range(2, 40);
    return 2 + $urandom_range((top - 2 < 24) ? top - 2 : 24);
  endfunction

  // mostly well-formed frames, with some line noise and broken sync words between them
  function automatic void queue_traffic(int unsigned n_bytes);
    int unsigned made;
    int unsigned roll;
    made = 0;
    while (made < n_bytes) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        repeat ($urandom_range(1, 6)) put_rx(8'($urandom));
      end else if (roll < 12) begin
        put_rx(SW0);
        put_rx(SW1);
        put_rx(SW2);
        put_rx(8'($urandom));
      end else begin
        made += queue_frame(16'($urandom), pick_length(), $urandom_range(9) != 0);
      end
    end
  endfunction

  task automatic wait_idle();
    while (rx_stream.size() != 0 || in_tvalid || reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_length(logic [15:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_len_model = v;
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= rx_stream.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reports_due.size() == 0) begin
          $error("result with none expected: kind %0d data 0x%0h", out_tuser, out_tdata[7:0]);
          n_errors++;
        end else begin
          want = reports_due.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_tuser));
          check_field("data_byte", 16'(want.data_byte), 16'(out_tdata[7:0]));
          check_field("command_code", want.command_code, out_tdata[23:8]);
          check_field("frame_length", want.frame_length, out_tdata[39:24]);
          check_field("frame_end", 16'(want.frame_end), 16'(out_tlast));
        end
        n_checked++;
        kind_seen[out_tuser]++;
      end
      out_tready <= !rx_blocked && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off so the result queue fills and the input stalls
  initial begin
    wait (long_stall_go);
    @(posedge clk);
    rx_blocked <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_blocked <= 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed cases under the reset max_length
    put_rx(8'h00);
    put_rx(8'hFF);
    put_rx(SW3);
    put_rx(SW0);
    put_rx(SW1);
    put_rx(SW2);
    put_rx(8'h00);
    // an extra leading sync byte, the window must still lock on
    put_rx(SW0);
    void'(queue_frame(16'h0000, 32'd2, 1'b1));
    void'(queue_frame(16'hFFFF, 32'd3, 1'b1));
    void'(queue_frame(16'h1234, 32'd4, 1'b0));
    void'(queue_frame(16'h00FF, 32'd0, 1'b1));
    void'(queue_frame(16'hFF00, 32'd1, 1'b1));
    void'(queue_frame(16'hA5A5, 32'd1025, 1'b1));
    void'(queue_frame(16'h5A5A, 32'hFFFF_FFFF, 1'b1));
    void'(queue_frame(16'h8001, 32'h0001_0002, 1'b1));
    queue_traffic(350);

    write_max_length(16'd2);
    send_idle_pct = 68;
    recv_idle_pct = 23;
    void'(queue_frame(16'h0102, 32'd2, 1'b1));
    void'(queue_frame(16'h0304, 32'd3, 1'b1));
    queue_traffic(150);
    // below two nothing is acceptable
    write_max_length(16'd0);
    queue_traffic(80);
    write_max_length(16'd1);
    queue_traffic(60);
    write_max_length(16'($urandom_range(3, 400)));
    void'(queue_frame(16'h4242, 32'(max_len_model), 1'b1));
    void'(queue_frame(16'h4243, 32'(max_len_model) + 1, 1'b1));
    queue_traffic(200);

    write_max_length(16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_stall_go = 1'b1;
    void'(queue_frame(16'hC0DE, 32'd80, 1'b1));
    void'(queue_frame(16'hC0DF, 32'h0001_0000, 1'b1));
    queue_traffic(250);
    write_max_length(16'd1024);
    queue_traffic(150);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes, %0d results: %0d body bytes, %0d good frames,",
             n_sent, n_checked, kind_seen[KIND_BODY], kind_seen[KIND_GOOD]);
    $display("%0d checksum mismatches, %0d bad lengths, max_length from 0 up to 65535",
             kind_seen[KIND_BADSUM], kind_seen[KIND_BADLEN]);
    if (n_errors == 0) begin
      $display("sync_header_frame_deframer_tb: PASS");
    end else begin
      $display("sync_header_frame_deframer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results still expected", reports_due.size());
    $display("sync_header_frame_deframer_tb: FAIL");
    $finish;
  end

endmodule
